// ===== hw/rtl/cnle_pkg.sv =====
// ----------------------------------------------------------------------------
// cnle_pkg
// Types, constants, microcode program and CRC step shared by the
// nibble length encoder.
// ----------------------------------------------------------------------------
package cnle_pkg;

  localparam int CNLE_MAX_LEN = 32;
  localparam int CNLE_CNT_W   = 6;

  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] TAG_CRC_L = 8'h02;
  localparam logic [7:0] TAG_CRC_H = 8'h03;
  localparam logic [7:0] TAG_LEN_L = 8'h04;
  localparam logic [7:0] TAG_LEN_H = 8'h05;
  localparam logic [7:0] TAG_BYTE0 = 8'h06;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } cnle_in_t;

  typedef struct packed {
    logic [11:0] symbol_first;
    logic [11:0] symbol_second;
    logic        is_final;
    logic        overflowed;
  } cnle_out_t;

  typedef enum logic [1:0] {
    STEP_ACCEPT = 2'd0,
    STEP_CRC    = 2'd1,
    STEP_LEN    = 2'd2,
    STEP_BYTE   = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    SEL_CRC  = 2'd0,
    SEL_LEN  = 2'd1,
    SEL_BYTE = 2'd2
  } sym_sel_t;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_LAST = 2'd1,
    COND_MORE = 2'd2
  } cond_t;

  // One control word per sequencer step.
  typedef struct packed {
    logic     take_in;
    logic     emit;
    sym_sel_t sel;
    cond_t    cond;
    step_t    jmp;
    step_t    nxt;
    logic     done;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      STEP_ACCEPT: w = '{take_in: 1'b1, emit: 1'b0, sel: SEL_CRC, cond: COND_LAST,
                         jmp: STEP_CRC, nxt: STEP_ACCEPT, done: 1'b0};
      STEP_CRC:    w = '{take_in: 1'b0, emit: 1'b1, sel: SEL_CRC, cond: COND_NONE,
                         jmp: STEP_LEN, nxt: STEP_LEN, done: 1'b0};
      STEP_LEN:    w = '{take_in: 1'b0, emit: 1'b1, sel: SEL_LEN, cond: COND_NONE,
                         jmp: STEP_BYTE, nxt: STEP_BYTE, done: 1'b0};
      STEP_BYTE:   w = '{take_in: 1'b0, emit: 1'b1, sel: SEL_BYTE, cond: COND_MORE,
                         jmp: STEP_BYTE, nxt: STEP_ACCEPT, done: 1'b1};
      default:     w = '{take_in: 1'b1, emit: 1'b0, sel: SEL_CRC, cond: COND_LAST,
                         jmp: STEP_CRC, nxt: STEP_ACCEPT, done: 1'b0};
    endcase
    return w;
  endfunction

  // Reflected CRC-8, one byte, least significant bit first.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                          input logic [7:0] b_in);
    logic [7:0] c;
    logic [7:0] b;
    c = crc_in;
    b = b_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crc_nibble_length_encoder.sv =====
// ----------------------------------------------------------------------------
// crc_nibble_length_encoder
// Stores message bytes, runs a reflected CRC-8 over them and emits the
// frame as tagged pairs of 12-bit nibble symbols.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel: one message byte per item, last_byte marks the final one.
//   Bytes are taken one per cycle in the accept step; each kept byte is stored and folded into
//   the CRC in the cycle it is accepted. Bytes beyond MAX_LEN are dropped
//   and the frame is marked overflowed.
//   sym channel: after the last byte, the frame goes out as len+2 items:
//   the CRC pair, the length pair, then one pair per stored byte.
//   The first pair is loaded into the output register from the CRC step that
//   follows the last byte, then one pair per cycle while the receiver takes them.
//   The rate is set by the four-step microcode sequencer: one step per
//   cycle unless stalled, the byte pairs read from the byte store one address per cycle.
//   No bytes are taken while a frame is being emitted.
//   When the receiver stalls, the current pair holds in the output register
//   and the sequencer waits on the emitting step.
//   Reset clears the sequencer, counters, CRC and output valid; the
//   byte store needs no clearing since only bytes of the current message
//   are read.
// ----------------------------------------------------------------------------
module crc_nibble_length_encoder #(
  parameter int MAX_LEN = cnle_pkg::CNLE_MAX_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_ready,
  input  cnle_pkg::cnle_in_t  msg,
  output logic                sym_valid,
  input  logic                sym_ready,
  output cnle_pkg::cnle_out_t sym
);
  import cnle_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNLE_CNT_W-1:0] MaxCnt = CNLE_CNT_W'(MAX_LEN);

  step_t                 step;
  step_t                 step_next;
  uword_t                uw;
  logic [CNLE_CNT_W-1:0] count;
  logic [CNLE_CNT_W-1:0] idx;
  logic [CNLE_CNT_W-1:0] idx_next;
  logic [7:0]            crc;
  logic                  ovf;
  logic [7:0]            byte_store [MAX_LEN];
  logic [7:0]            rd_data;
  logic                  in_fire;
  logic                  load_ok;
  logic                  fire;
  logic                  more;
  logic                  take_jump;
  logic                  store_ok;
  logic [7:0]            byte_tag;
  cnle_out_t             pair;

  assign uw        = ucode(step);
  assign msg_ready = uw.take_in;
  assign in_fire   = msg_valid && msg_ready;
  assign load_ok   = !sym_valid || sym_ready;
  assign fire      = (!uw.take_in || in_fire) && (!uw.emit || load_ok);
  assign more      = (CNLE_CNT_W'(idx + 1'b1) != count);
  assign store_ok  = (count < MaxCnt);

  always_comb begin
    unique case (uw.cond)
      COND_LAST: take_jump = msg.last_byte;
      COND_MORE: take_jump = more;
      default:   take_jump = 1'b1;
    endcase
    step_next = step;
    if (fire) begin
      step_next = take_jump ? uw.jmp : uw.nxt;
    end
  end

  // Byte index advances on each byte pair emitted and wraps to zero at the
  // end of the frame; the store read below is addressed with the next index, so rd_data matches idx.
  always_comb begin
    idx_next = idx;
    if (fire && uw.sel == SEL_BYTE && uw.emit) begin
      idx_next = more ? CNLE_CNT_W'(idx + 1'b1) : '0;
    end
  end

  assign byte_tag = 8'(TAG_BYTE0 + {idx, 1'b0});

  always_comb begin
    pair.overflowed = ovf;
    pair.is_final   = 1'b0;
    unique case (uw.sel)
      SEL_CRC: begin
        pair.symbol_first  = {TAG_CRC_L, crc[3:0]};
        pair.symbol_second = {TAG_CRC_H, crc[7:4]};
      end
      SEL_LEN: begin
        pair.symbol_first  = {TAG_LEN_L, count[3:0]};
        pair.symbol_second = {TAG_LEN_H, 2'b00, count[5:4]};
      end
      SEL_BYTE: begin
        pair.symbol_first  = {byte_tag, rd_data[3:0]};
        pair.symbol_second = {8'(byte_tag + 1'b1), rd_data[7:4]};
        pair.is_final      = !more;
      end
      default: begin
        pair.symbol_first  = '0;
        pair.symbol_second = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      byte_store[count[AW-1:0]] <= msg.msg_byte;
    end
    rd_data <= byte_store[idx_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_ACCEPT;
      count     <= '0;
      idx       <= '0;
      crc       <= '0;
      ovf       <= 1'b0;
      sym_valid <= 1'b0;
    end else begin
      step <= step_next;
      idx  <= idx_next;
      if (in_fire) begin
        if (store_ok) begin
          count <= CNLE_CNT_W'(count + 1'b1);
          crc   <= crc_fold(crc, msg.msg_byte);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (fire && uw.emit) begin
        sym_valid <= 1'b1;
      end else if (sym_ready) begin
        sym_valid <= 1'b0;
      end
      if (fire && uw.done && !more) begin
        count <= '0;
        crc   <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && uw.emit) begin
      sym <= pair;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCnt)
    else $error("byte count beyond storage depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == MaxCnt)
    else $error("overflow flagged while storage not full");

  a_byte_idx: assert property (@(posedge clk) disable iff (rst)
    step == STEP_BYTE |-> idx < count)
    else $error("byte pair index past message length");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    fire && uw.done && !more |=> count == '0 && crc == '0 && !ovf && idx == '0)
    else $error("state not cleared after final pair");

  a_no_take_emit: assert property (@(posedge clk) disable iff (rst)
    step != STEP_ACCEPT |-> !msg_ready)
    else $error("byte taken while frame is being emitted");

endmodule
